/* rtl/pcbp_pkg.sv */
// Shared types and constants for the prefix code bit packer.
// Holds the sequencer state type, request function codes and datapath widths.
// No dependencies.
`timescale 1ns / 1ps

package pcbp_pkg;

	// Width of a code word and of one packed output byte.
	localparam int CODE_W = 32;
	localparam int BYTE_W = 8;
	// Bits of a partial byte that can be left between requests.
	localparam int ACC_W = BYTE_W - 1;
	// Working stream: a partial byte in front of a full code word.
	localparam int STREAM_W = CODE_W + BYTE_W;
	// Width of the length field and of the bit count in the stream.
	localparam int LEN_W = 6;
	localparam int PEND_W = 3;

	// Defaults for the top level parameters.
	localparam int DEF_MAX_CODE_LEN = 32;
	localparam int DEF_SYMBOL_COUNT = 256;

	typedef enum logic [1:0] {
		FUNC_LOAD   = 2'd0,
		FUNC_ENCODE = 2'd1,
		FUNC_FLUSH  = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALIGN,
		ST_MERGE,
		ST_EMIT,
		ST_ERROR,
		ST_FLUSH
	} state_t;

endpackage

/* rtl/prefix_code_bit_packer_unit.sv */
// A load completes in idle; an encode runs align and merge, emits up to four bytes, each
// held until taken, then closes; a flush or error result is held until taken.
// Requests are taken one at a time; in_ready is high only while the sequencer is idle,
// and the shared shifter is busy for the align, merge and every byte step of an encode.
// Reset (arst_n low) clears the sequencer, the partial byte and all symbol defined flags;
// the code table itself is not cleared and needs no clearing pass.
// Depends on pcbp_pkg.
`timescale 1ns / 1ps

module prefix_code_bit_packer_unit #(
	parameter int MAX_CODE_LEN = pcbp_pkg::DEF_MAX_CODE_LEN,
	parameter int SYMBOL_COUNT = pcbp_pkg::DEF_SYMBOL_COUNT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Request channel.
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    func,
	input  logic [7:0]                    symbol,
	input  logic [pcbp_pkg::CODE_W-1:0]   code_word,
	input  logic [pcbp_pkg::LEN_W-1:0]    code_length,
	// Result channel.
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pcbp_pkg::BYTE_W-1:0]   out_byte,
	output logic                          is_error,
	output logic                          last
);

	// Table index width and the length cap: codes never exceed the code word width.
	localparam int SYM_AW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int LEN_CAP = (MAX_CODE_LEN < pcbp_pkg::CODE_W) ? MAX_CODE_LEN
		: pcbp_pkg::CODE_W;
	localparam int ENTRY_W = pcbp_pkg::CODE_W + pcbp_pkg::LEN_W;
	localparam int SHAMT_W = $clog2(pcbp_pkg::STREAM_W);

	pcbp_pkg::state_t state_q, state_d;

	// The code table stores the code word and its saturated length per symbol.
	// A symbol's entry is only used after it was loaded, so the table needs no reset;
	// the defined flags live in flip-flops and are cleared at reset.
	logic [ENTRY_W-1:0]                 table_mem [SYMBOL_COUNT];
	logic [ENTRY_W-1:0]                 rd_q;
	logic [SYMBOL_COUNT-1:0]            defined_q;

	// The partial byte is kept left-aligned: its pend_q valid bits sit at the top and
	// the bits below them are always zero, so a flush emits it directly.
	logic [pcbp_pkg::ACC_W-1:0]         acc_q;
	logic [pcbp_pkg::PEND_W-1:0]        pend_q;

	// The working stream holds the partial byte followed by the new code, MSB first.
	logic [pcbp_pkg::STREAM_W-1:0]      stream_q;
	logic [pcbp_pkg::LEN_W-1:0]         count_q;

	logic                               accept_in;
	logic                               accept_out;
	logic [SYM_AW-1:0]                  sym_addr;
	logic                               sym_in_range;
	logic                               sym_defined;
	logic [pcbp_pkg::LEN_W-1:0]         len_sat;
	logic [pcbp_pkg::CODE_W-1:0]        rd_code;
	logic [pcbp_pkg::LEN_W-1:0]         rd_len;
	logic                               byte_ready;

	// Shared shifter used by the align, merge and byte steps.
	logic [pcbp_pkg::STREAM_W-1:0]      sh_in;
	logic [SHAMT_W-1:0]                 sh_amt;
	logic                               sh_left;
	logic [pcbp_pkg::STREAM_W-1:0]      sh_out;

	assign accept_in  = in_valid && in_ready;
	assign accept_out = out_valid && out_ready;

	assign sym_addr     = symbol[SYM_AW-1:0];
	assign sym_in_range = {1'b0, symbol} < 9'(SYMBOL_COUNT);
	assign sym_defined  = sym_in_range && defined_q[sym_addr];

	// Lengths beyond the cap are clipped on load.
	assign len_sat = (code_length > pcbp_pkg::LEN_W'(LEN_CAP)) ? pcbp_pkg::LEN_W'(LEN_CAP)
		: code_length;

	assign rd_code = rd_q[pcbp_pkg::CODE_W-1:0];
	assign rd_len  = rd_q[ENTRY_W-1:pcbp_pkg::CODE_W];

	// A full byte sits at the top of the stream while at least eight bits remain.
	assign byte_ready = count_q >= pcbp_pkg::LEN_W'(pcbp_pkg::BYTE_W);

	// Shift operand selection. Align moves the right-aligned code to the top of the
	// stream, which also drops any stray bits above its length. Merge moves it down
	// behind the pending bits. Each byte step moves the stream up by one byte.
	always_comb begin
		sh_in   = stream_q;
		sh_amt  = SHAMT_W'(pcbp_pkg::BYTE_W);
		sh_left = 1'b1;
		case (state_q)
			pcbp_pkg::ST_ALIGN: begin
				sh_in   = {rd_code, {pcbp_pkg::BYTE_W{1'b0}}};
				sh_amt  = SHAMT_W'(pcbp_pkg::CODE_W) - SHAMT_W'(rd_len);
				sh_left = 1'b1;
			end
			pcbp_pkg::ST_MERGE: begin
				sh_in   = stream_q;
				sh_amt  = SHAMT_W'(pend_q);
				sh_left = 1'b0;
			end
			default: begin
				sh_in   = stream_q;
				sh_amt  = SHAMT_W'(pcbp_pkg::BYTE_W);
				sh_left = 1'b1;
			end
		endcase
	end

	assign sh_out = sh_left ? (sh_in << sh_amt) : (sh_in >> sh_amt);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			pcbp_pkg::ST_IDLE: begin
				if (accept_in) begin
					case (func)
						pcbp_pkg::FUNC_ENCODE: begin
							state_d = sym_defined ? pcbp_pkg::ST_ALIGN : pcbp_pkg::ST_ERROR;
						end
						pcbp_pkg::FUNC_FLUSH: begin
							if (pend_q != '0) begin
								state_d = pcbp_pkg::ST_FLUSH;
							end
						end
						default: begin
							state_d = pcbp_pkg::ST_IDLE;
						end
					endcase
				end
			end
			pcbp_pkg::ST_ALIGN: begin
				state_d = pcbp_pkg::ST_MERGE;
			end
			pcbp_pkg::ST_MERGE: begin
				state_d = pcbp_pkg::ST_EMIT;
			end
			pcbp_pkg::ST_EMIT: begin
				if (!byte_ready) begin
					state_d = pcbp_pkg::ST_IDLE;
				end
			end
			pcbp_pkg::ST_ERROR, pcbp_pkg::ST_FLUSH: begin
				if (accept_out) begin
					state_d = pcbp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pcbp_pkg::ST_IDLE;
			end
		endcase
	end

	// Handshake and result outputs.
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		out_byte  = '0;
		is_error  = 1'b0;
		last      = 1'b0;
		case (state_q)
			pcbp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			pcbp_pkg::ST_EMIT: begin
				out_valid = byte_ready;
				out_byte  = stream_q[pcbp_pkg::STREAM_W-1 -: pcbp_pkg::BYTE_W];
				// The last byte of the request leaves fewer than eight bits behind.
				last      = count_q < pcbp_pkg::LEN_W'(2 * pcbp_pkg::BYTE_W);
			end
			pcbp_pkg::ST_ERROR: begin
				out_valid = 1'b1;
				is_error  = 1'b1;
				last      = 1'b1;
			end
			pcbp_pkg::ST_FLUSH: begin
				out_valid = 1'b1;
				out_byte  = {acc_q, 1'b0};
				last      = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcbp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Defined flags, partial byte and bit count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			defined_q <= '0;
			acc_q     <= '0;
			pend_q    <= '0;
			count_q   <= '0;
		end else begin
			case (state_q)
				pcbp_pkg::ST_IDLE: begin
					if (accept_in && func == pcbp_pkg::FUNC_LOAD && sym_in_range) begin
						defined_q[sym_addr] <= 1'b1;
					end
				end
				pcbp_pkg::ST_MERGE: begin
					count_q <= pcbp_pkg::LEN_W'(pend_q) + rd_len;
				end
				pcbp_pkg::ST_EMIT: begin
					if (!byte_ready) begin
						// Whatever is left becomes the new partial byte.
						acc_q  <= stream_q[pcbp_pkg::STREAM_W-1 -: pcbp_pkg::ACC_W];
						pend_q <= count_q[pcbp_pkg::PEND_W-1:0];
					end else if (accept_out) begin
						count_q <= count_q - pcbp_pkg::LEN_W'(pcbp_pkg::BYTE_W);
					end
				end
				pcbp_pkg::ST_FLUSH: begin
					if (accept_out) begin
						acc_q  <= '0;
						pend_q <= '0;
					end
				end
				default: begin
					pend_q <= pend_q;
				end
			endcase
		end
	end

	// Working stream.
	always_ff @(posedge clk) begin
		case (state_q)
			pcbp_pkg::ST_ALIGN: begin
				stream_q <= sh_out;
			end
			pcbp_pkg::ST_MERGE: begin
				stream_q <= {acc_q, {(pcbp_pkg::STREAM_W - pcbp_pkg::ACC_W){1'b0}}} | sh_out;
			end
			pcbp_pkg::ST_EMIT: begin
				if (byte_ready && accept_out) begin
					stream_q <= sh_out;
				end
			end
			default: begin
				stream_q <= stream_q;
			end
		endcase
	end

	// Code table: written by a load request, read whenever a request is taken.
	always_ff @(posedge clk) begin
		if (accept_in) begin
			if (func == pcbp_pkg::FUNC_LOAD && sym_in_range) begin
				table_mem[sym_addr] <= {len_sat, code_word};
			end
			rd_q <= table_mem[sym_addr];
		end
	end

	// An error result always closes its request.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_error) |-> last)
		else $error("error result without last");

	// Bits below the pending ones in the partial byte stay zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(acc_q & (7'h7F >> pend_q)) == '0)
		else $error("partial byte holds stray bits");

	// Right after the final result of a request is taken, no result is offered, and the
	// block is idle again unless an encode still has its closing step to run.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last) |=>
			(!out_valid && (in_ready || state_q == pcbp_pkg::ST_EMIT)))
		else $error("not returning to idle after final result");

	// A load request completes in its own cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && func == pcbp_pkg::FUNC_LOAD) |=> (in_ready && !out_valid))
		else $error("load request did not complete at once");

endmodule

/* sim/pcbp_checker.sv */
// Result checker for the prefix code bit packer: watches both channels, predicts results.
// Keeps its own code table and partial byte; depends on pcbp_pkg.
`timescale 1ns / 1ps

module pcbp_checker #(
	parameter int MAX_CODE_LEN = pcbp_pkg::DEF_MAX_CODE_LEN,
	parameter int SYMBOL_COUNT = pcbp_pkg::DEF_SYMBOL_COUNT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [1:0]                  func,
	input  logic [7:0]                  symbol,
	input  logic [pcbp_pkg::CODE_W-1:0] code_word,
	input  logic [pcbp_pkg::LEN_W-1:0]  code_length,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [pcbp_pkg::BYTE_W-1:0] out_byte,
	input  logic                        is_error,
	input  logic                        last,
	output int                          mismatches,
	output int                          outstanding,
	output int                          bytes_checked
);

	localparam int LEN_CAP = (MAX_CODE_LEN < pcbp_pkg::CODE_W) ? MAX_CODE_LEN
		: pcbp_pkg::CODE_W;

	typedef struct packed {
		logic [pcbp_pkg::BYTE_W-1:0] data;
		logic                        err;
		logic                        is_last;
	} packed_out_t;

	logic [pcbp_pkg::CODE_W-1:0] code_mem [SYMBOL_COUNT];
	logic [pcbp_pkg::LEN_W-1:0]  len_mem  [SYMBOL_COUNT];
	bit                          sym_defined [SYMBOL_COUNT];
	logic [pcbp_pkg::ACC_W-1:0]  acc_bits;
	int                          acc_cnt;
	packed_out_t                 expected_bytes [$];
	int                          fail_tally;
	int                          seen_tally;

	// Applies one accepted request to the shadow state and queues the bytes it yields.
	task automatic pack_request(input logic [1:0] f, input logic [7:0] s,
			input logic [pcbp_pkg::CODE_W-1:0] w, input logic [pcbp_pkg::LEN_W-1:0] l);
		logic [pcbp_pkg::BYTE_W-1:0] shreg;
		packed_out_t                 item;
		int                          cnt;
		int                          clen;
		int                          nbytes;
		int                          emitted;
		int                          i;
		case (f)
			pcbp_pkg::FUNC_LOAD: begin
				if (s < SYMBOL_COUNT) begin
					code_mem[s] = w;
					len_mem[s] = (l > LEN_CAP) ? pcbp_pkg::LEN_W'(LEN_CAP) : l;
					sym_defined[s] = 1'b1;
				end
			end
			pcbp_pkg::FUNC_ENCODE: begin
				if (s >= SYMBOL_COUNT || !sym_defined[s]) begin
					item.data = '0;
					item.err = 1'b1;
					item.is_last = 1'b1;
					expected_bytes.push_back(item);
				end else begin
					clen = len_mem[s];
					nbytes = (acc_cnt + clen) / pcbp_pkg::BYTE_W;
					shreg = {1'b0, acc_bits};
					cnt = acc_cnt;
					emitted = 0;
					for (i = clen; i > 0; i--) begin
						shreg = {shreg[pcbp_pkg::BYTE_W-2:0], code_mem[s][i-1]};
						cnt++;
						if (cnt == pcbp_pkg::BYTE_W) begin
							emitted++;
							item.data = shreg;
							item.err = 1'b0;
							item.is_last = (emitted == nbytes);
							expected_bytes.push_back(item);
							shreg = '0;
							cnt = 0;
						end
					end
					acc_bits = shreg[pcbp_pkg::ACC_W-1:0];
					acc_cnt = cnt;
				end
			end
			pcbp_pkg::FUNC_FLUSH: begin
				if (acc_cnt != 0) begin
					item.data = {1'b0, acc_bits} << (pcbp_pkg::BYTE_W - acc_cnt);
					item.err = 1'b0;
					item.is_last = 1'b1;
					expected_bytes.push_back(item);
					acc_bits = '0;
					acc_cnt = 0;
				end
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		packed_out_t exp_item;
		if (!arst_n) begin
			for (int k = 0; k < SYMBOL_COUNT; k++)
				sym_defined[k] = 1'b0;
			acc_bits = '0;
			acc_cnt = 0;
			expected_bytes.delete();
			fail_tally = 0;
			seen_tally = 0;
			mismatches <= 0;
			outstanding <= 0;
			bytes_checked <= 0;
		end else begin
			// The block never accepts a request and returns its result on the same edge,
			// so the output side is handled first.
			if (out_valid && out_ready) begin
				seen_tally++;
				if (expected_bytes.size() == 0) begin
					$error("result with nothing expected: out_byte %02h, is_error %0b, last %0b",
						out_byte, is_error, last);
					fail_tally++;
				end else begin
					exp_item = expected_bytes.pop_front();
					if (out_byte !== exp_item.data) begin
						$error("out_byte: expected %02h, got %02h", exp_item.data, out_byte);
						fail_tally++;
					end
					if (is_error !== exp_item.err) begin
						$error("is_error: expected %0b, got %0b", exp_item.err, is_error);
						fail_tally++;
					end
					if (last !== exp_item.is_last) begin
						$error("last: expected %0b, got %0b", exp_item.is_last, last);
						fail_tally++;
					end
				end
			end
			if (in_valid && in_ready)
				pack_request(func, symbol, code_word, code_length);
			mismatches <= fail_tally;
			outstanding <= expected_bytes.size();
			bytes_checked <= seen_tally;
		end
	end

endmodule

/* sim/tb.sv */
// Top of the prefix code bit packer testbench: clock, reset, request and result traffic.
// Instantiates the block and pcbp_checker beside it; depends on pcbp_pkg.
`timescale 1ns / 1ps

module tb;

	// The unused function code; the block must swallow it without a result.
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	// Receiver hold-off that backs the block up into its request channel.
	localparam int LONG_HOLD = 300;
	localparam int HOLD_AT_RESULT = 40;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_ready;
	logic [1:0]                  func;
	logic [7:0]                  symbol;
	logic [pcbp_pkg::CODE_W-1:0] code_word;
	logic [pcbp_pkg::LEN_W-1:0]  code_length;
	logic                        out_valid;
	logic                        out_ready;
	logic [pcbp_pkg::BYTE_W-1:0] out_byte;
	logic                        is_error;
	logic                        last;

	int mismatches;
	int outstanding;
	int bytes_checked;

	// Request counts by kind, only for the closing summary.
	int n_load;
	int n_encode;
	int n_flush;
	int n_ignored;

	// Symbols that have been given a code, so most encodes hit a defined entry.
	logic [7:0] loaded_syms [$];
	// When set, the sender offers requests back to back.
	bit in_burst;

	prefix_code_bit_packer_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.symbol     (symbol),
		.code_word  (code_word),
		.code_length(code_length),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.is_error   (is_error),
		.last       (last)
	);

	pcbp_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.symbol       (symbol),
		.code_word    (code_word),
		.code_length  (code_length),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.is_error     (is_error),
		.last         (last),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.bytes_checked(bytes_checked)
	);

	always #1 clk = ~clk;

	// Offers one request after a random gap and returns on the edge that accepts it.
	// Valid stays high on return so that a following request with no gap runs on
	// without a bubble; a gap lowers it first.
	task automatic send_request(input logic [1:0] f, input logic [7:0] s,
			input logic [pcbp_pkg::CODE_W-1:0] w, input logic [pcbp_pkg::LEN_W-1:0] l);
		int gap;
		if ($urandom_range(0, 15) == 0)
			in_burst = !in_burst;
		gap = in_burst ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		symbol <= s;
		code_word <= w;
		code_length <= l;
		do @(posedge clk); while (!in_ready);
		case (f)
			pcbp_pkg::FUNC_LOAD:   n_load++;
			pcbp_pkg::FUNC_ENCODE: n_encode++;
			pcbp_pkg::FUNC_FLUSH:  n_flush++;
			default:               n_ignored++;
		endcase
	endtask

	task automatic load_code(input logic [7:0] s, input logic [pcbp_pkg::CODE_W-1:0] w,
			input logic [pcbp_pkg::LEN_W-1:0] l);
		send_request(pcbp_pkg::FUNC_LOAD, s, w, l);
		loaded_syms.push_back(s);
	endtask

	// Result side: a random stall before every byte, with stretches of none, and one
	// long hold-off part way through so that the block fills up and stops taking requests.
	initial begin : result_sink
		int  gap;
		int  taken;
		bit  out_burst;
		out_ready = 1'b0;
		taken = 0;
		out_burst = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0)
				out_burst = !out_burst;
			gap = out_burst ? 0 : $urandom_range(0, 10);
			if (taken == HOLD_AT_RESULT)
				gap = LONG_HOLD;
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	initial begin : stimulus
		int                         sel;
		int                         r;
		logic [pcbp_pkg::LEN_W-1:0] l;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = pcbp_pkg::FUNC_LOAD;
		symbol = '0;
		code_word = '0;
		code_length = '0;
		n_load = 0;
		n_encode = 0;
		n_flush = 0;
		n_ignored = 0;
		in_burst = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Nothing is defined yet, so both ends of the symbol range
		// must come back as errors, and a flush with nothing pending says nothing.
		send_request(pcbp_pkg::FUNC_ENCODE, 8'h00, '0, '0);
		send_request(pcbp_pkg::FUNC_ENCODE, 8'hFF, '0, '0);
		send_request(pcbp_pkg::FUNC_FLUSH, 8'h00, '0, '0);
		send_request(FUNC_UNUSED, 8'hA5, 32'hFFFF_FFFF, 6'h3F);
		// Shortest and longest codes, lengths above 32 that must saturate, and an
		// empty code that is defined but contributes no bits.
		load_code(8'h00, 32'h0000_0001, 6'd1);
		load_code(8'hFF, 32'hFFFF_FFFF, 6'd32);
		load_code(8'h55, 32'hAAAA_AAAA, 6'd63);
		load_code(8'hAA, 32'h1234_5678, 6'd0);
		load_code(8'h0F, 32'h0000_0005, 6'd3);
		load_code(8'hF0, 32'h0000_0000, 6'd33);
		// Empty code, then a single bit that completes no byte; the flush pads it out.
		send_request(pcbp_pkg::FUNC_ENCODE, 8'hAA, '0, '0);
		send_request(pcbp_pkg::FUNC_ENCODE, 8'h00, '0, '0);
		send_request(pcbp_pkg::FUNC_FLUSH, 8'h00, '0, '0);
		// A full 32-bit code on an empty accumulator, then on three pending bits.
		send_request(pcbp_pkg::FUNC_ENCODE, 8'hFF, '0, '0);
		send_request(pcbp_pkg::FUNC_ENCODE, 8'h0F, '0, '0);
		send_request(pcbp_pkg::FUNC_ENCODE, 8'hFF, '0, '0);
		send_request(pcbp_pkg::FUNC_ENCODE, 8'h55, '0, '0);
		// Push the accumulator to seven pending bits before a long code.
		send_request(pcbp_pkg::FUNC_ENCODE, 8'h0F, '0, '0);
		send_request(pcbp_pkg::FUNC_ENCODE, 8'h00, '0, '0);
		send_request(pcbp_pkg::FUNC_ENCODE, 8'hFF, '0, '0);
		// An undefined symbol in the middle must leave the pending bits alone.
		send_request(pcbp_pkg::FUNC_ENCODE, 8'h01, '0, '0);
		send_request(pcbp_pkg::FUNC_FLUSH, 8'h00, '0, '0);
		send_request(pcbp_pkg::FUNC_ENCODE, 8'hF0, '0, '0);
		// Overwriting an entry takes effect on the next encode.
		load_code(8'h00, 32'h0000_0003, 6'd2);
		send_request(pcbp_pkg::FUNC_ENCODE, 8'h00, '0, '0);
		send_request(pcbp_pkg::FUNC_FLUSH, 8'h00, '0, '0);

		// A working set of random codes before the random traffic.
		repeat (16)
			load_code(8'($urandom_range(0, 255)), $urandom, 6'($urandom_range(1, 32)));

		// Random part: mostly encodes of defined symbols, with flushes, reloads,
		// stray symbols and the odd unused function code mixed in.
		for (int k = 0; k < 100; k++) begin
			if ($urandom_range(0, 24) == 0)
				send_request(FUNC_UNUSED, 8'($urandom), $urandom, 6'($urandom));
			sel = $urandom_range(0, 99);
			if (sel < 66) begin
				send_request(pcbp_pkg::FUNC_ENCODE,
					loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
					$urandom, 6'($urandom));
			end else if (sel < 74) begin
				send_request(pcbp_pkg::FUNC_ENCODE, 8'($urandom_range(0, 255)), $urandom,
					6'($urandom));
			end else if (sel < 84) begin
				send_request(pcbp_pkg::FUNC_FLUSH, 8'($urandom), $urandom, 6'($urandom));
			end else begin
				// Lengths are mostly short, with some long, empty and saturating ones.
				r = $urandom_range(0, 19);
				if (r == 0)
					l = 6'd0;
				else if (r == 1)
					l = 6'($urandom_range(33, 63));
				else if (r < 10)
					l = 6'($urandom_range(1, 8));
				else
					l = 6'($urandom_range(1, 32));
				load_code(8'($urandom_range(0, 255)), $urandom, l);
			end
		end
		in_valid <= 1'b0;

		// Let the checker see the last accepted request, drain every expected byte,
		// then give a stray result time to show up.
		@(posedge clk);
		wait (outstanding == 0);
		repeat (20) @(posedge clk);
		@(negedge clk);

		$display("Covered %0d loads, %0d encodes, %0d flushes and %0d unused-code requests;",
			n_load, n_encode, n_flush, n_ignored);
		$display("%0d result bytes checked, including one long receiver hold-off.",
			bytes_checked);
		if (mismatches == 0 && outstanding == 0)
			$display("** prefix_code_bit_packer_unit: PASSED **");
		else
			$display("** prefix_code_bit_packer_unit: FAILED **");
		$finish;
	end

	// Watchdog, far above the slowest legal run of this traffic.
	initial begin : watchdog
		#500000;
		$display("** prefix_code_bit_packer_unit: FAILED **");
		$finish;
	end

endmodule
